/* rtl/core/omni_wheel_velocity_mixer_unit_macros.svh */
// Assertion macros for the omni wheel velocity mixer.
// Included by the top level; needs i_clk and i_rst_n in scope.
`ifndef OMNI_WHEEL_VELOCITY_MIXER_UNIT_MACROS_SVH
`define OMNI_WHEEL_VELOCITY_MIXER_UNIT_MACROS_SVH

// Checks an implication on every clock edge outside of reset.
`define OWVM_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks an implication in the following cycle outside of reset.
`define OWVM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/owvm_pkg.sv */
// Shared types, constants and the quarter-wave sine table of the velocity mixer.
// No dependencies.
`default_nettype none

package owvm_pkg;

    localparam int CFG_W      = 9;
    localparam int CFG_RESET  = 256;
    localparam int ANG_FULL   = 5760;
    localparam int ANG_QUARTER = 1440;
    localparam int SPEED_MAX  = 100;
    localparam int WHEEL_GAIN = 15;
    localparam int NUM_WHEELS = 4;

    localparam int ANG_W = 13;
    localparam int ARG_W = 11;
    localparam int SIN_W = 12;
    localparam int SPD_W = 7;
    localparam int MAG_W = 16;
    localparam int REM_W = 30;
    localparam int Q_W   = 15;
    localparam int DIV_STEPS = Q_W;

    // Wheel angle offsets in 1/16 degree: front right, front left, rear right, rear left.
    localparam logic [13:0] WHEEL_OFF [NUM_WHEELS] = '{14'd880, 14'd4880, 14'd2320, 14'd3440};

    typedef logic [SIN_W-1:0] t_sin_tab [0:ANG_QUARTER];

    typedef struct packed {
        logic [NUM_WHEELS-1:0] vneg;
        logic                  zero;
    } t_div_side;

    // 15 * sin in Q4.8 from a truncated Q30 Horner series, evaluated at elaboration.
    function automatic t_sin_tab build_sin_tab();
        t_sin_tab          tab;
        longint unsigned   x;
        longint unsigned   x2;
        longint unsigned   t;
        longint unsigned   s;
        longint unsigned   one;
        one = 64'd1 << 30;
        for (int r = 0; r <= ANG_QUARTER; r++) begin
            x  = longint'(r) * 64'd1171271;
            x2 = (x * x) >> 30;
            t  = one - x2 / 64'd72;
            t  = one - ((x2 * t) >> 30) / 64'd42;
            t  = one - ((x2 * t) >> 30) / 64'd20;
            t  = one - ((x2 * t) >> 30) / 64'd6;
            s  = (x * t) >> 30;
            tab[r] = SIN_W'((64'd15 * s + (64'd1 << 21)) >> 22);
        end
        return tab;
    endfunction

    localparam t_sin_tab SIN_TAB = build_sin_tab();

endpackage

`default_nettype wire

/* rtl/core/owvm_if.sv */
// Valid/ready channel interfaces for the item and result streams of the mixer.
// No dependencies.
`default_nettype none

interface owvm_in_if;
    logic               valid;
    logic               ready;
    logic signed [13:0] travel_direction;
    logic signed [13:0] chassis_heading;
    logic signed [15:0] rotation_correction;
    logic [7:0]         speed_request;
    logic               slowdown;

    modport source (output valid, travel_direction, chassis_heading, rotation_correction,
                    speed_request, slowdown, input ready);
    modport sink (input valid, travel_direction, chassis_heading, rotation_correction,
                  speed_request, slowdown, output ready);
endinterface

interface owvm_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] front_right_speed;
    logic signed [15:0] front_left_speed;
    logic signed [15:0] rear_right_speed;
    logic signed [15:0] rear_left_speed;
    logic               zero_norm;

    modport source (output valid, front_right_speed, front_left_speed, rear_right_speed,
                    rear_left_speed, zero_norm, input ready);
    modport sink (input valid, front_right_speed, front_left_speed, rear_right_speed,
                  rear_left_speed, zero_norm, output ready);
endinterface

`default_nettype wire

/* rtl/core/owvm_sin_rom.sv */
// Quarter-wave sine ROM with registered read.
// Depends on owvm_pkg for the table.
`default_nettype none

module owvm_sin_rom (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [owvm_pkg::ARG_W-1:0]    i_addr,
    output logic [owvm_pkg::SIN_W-1:0]    o_data
);
    import owvm_pkg::*;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_data <= SIN_TAB[i_addr];
        end
    end

endmodule

`default_nettype wire

/* rtl/core/owvm_div_pipe.sv */
// Pipelined restoring divider, one quotient bit per stage, four lanes with one divisor.
// Depends on owvm_pkg.
`default_nettype none

module owvm_div_pipe (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_en,
    input  logic                                          i_valid,
    input  logic [owvm_pkg::NUM_WHEELS-1:0][owvm_pkg::REM_W-1:0] i_num,
    input  logic [owvm_pkg::MAG_W-1:0]                    i_div,
    input  owvm_pkg::t_div_side                           i_side,
    output logic                                          o_valid,
    output logic [owvm_pkg::NUM_WHEELS-1:0][owvm_pkg::Q_W-1:0]   o_quo,
    output owvm_pkg::t_div_side                           o_side
);
    import owvm_pkg::*;

    logic [DIV_STEPS-1:0]                     r_valid;
    logic [NUM_WHEELS-1:0][REM_W-1:0]         r_rem  [DIV_STEPS-1];
    logic [NUM_WHEELS-1:0][Q_W-1:0]           r_quo  [DIV_STEPS];
    logic [MAG_W-1:0]                         r_div  [DIV_STEPS-1];
    t_div_side                                r_side [DIV_STEPS];

    for (genvar s = 0; s < DIV_STEPS; s++) begin : g_step
        localparam int K = DIV_STEPS - 1 - s;

        logic [NUM_WHEELS-1:0][REM_W-1:0] a_rem;
        logic [NUM_WHEELS-1:0][Q_W-1:0]   a_quo;
        logic [MAG_W-1:0]                 a_div;
        t_div_side                        a_side;
        logic                             a_valid;
        logic [NUM_WHEELS-1:0][REM_W-1:0] n_rem;
        logic [NUM_WHEELS-1:0][Q_W-1:0]   n_quo;

        if (s == 0) begin : g_first
            assign a_rem   = i_num;
            assign a_quo   = '0;
            assign a_div   = i_div;
            assign a_side  = i_side;
            assign a_valid = i_valid;
        end else begin : g_next
            assign a_rem   = r_rem[s-1];
            assign a_quo   = r_quo[s-1];
            assign a_div   = r_div[s-1];
            assign a_side  = r_side[s-1];
            assign a_valid = r_valid[s-1];
        end

        always_comb begin
            logic [REM_W-1:0] sh;
            sh = REM_W'(a_div) << K;
            for (int l = 0; l < NUM_WHEELS; l++) begin
                if (a_rem[l] >= sh) begin
                    n_rem[l] = a_rem[l] - sh;
                    n_quo[l] = a_quo[l] | (Q_W'(1) << K);
                end else begin
                    n_rem[l] = a_rem[l];
                    n_quo[l] = a_quo[l];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[s] <= 1'b0;
            end else if (i_en) begin
                r_valid[s] <= a_valid;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_quo[s]  <= n_quo;
                r_side[s] <= a_side;
            end
        end

        // The last step needs neither the remainder nor the divisor afterwards.
        if (s < DIV_STEPS - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[s] <= n_rem;
                    r_div[s] <= a_div;
                end
            end
        end
    end

    assign o_valid = r_valid[DIV_STEPS-1];
    assign o_quo   = r_quo[DIV_STEPS-1];
    assign o_side  = r_side[DIV_STEPS-1];

endmodule

`default_nettype wire

/* rtl/core/omni_wheel_velocity_mixer_unit.sv */
// Path: each input passes through stage registers 1 to 6, the divider steps and the output
// register; the result transfers once it is valid and the output is ready.
// Throughput: one item per cycle; the whole pipeline advances together and holds
// while a finished result waits, with no loss or repetition.
// The depth is set by the 15-step pipelined divider that scales the wheel terms.
// Reset (synchronous, active low) empties the pipeline and sets the factor to 256.
// Depends on owvm_pkg, owvm_if, owvm_sin_rom, owvm_div_pipe and the macro header.
`default_nettype none

`include "omni_wheel_velocity_mixer_unit_macros.svh"

module omni_wheel_velocity_mixer_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [owvm_pkg::CFG_W-1:0]    i_cfg_data,
    owvm_in_if.sink                       i_in,
    owvm_out_if.source                    o_out
);
    import owvm_pkg::*;

    logic en;

    logic [CFG_W-1:0] r_slow_factor;

    logic             r1_valid;
    logic [SPD_W-1:0] r1_speed;
    logic [ANG_W-1:0] r1_d;
    logic signed [15:0] r1_corr;
    logic [SPD_W-1:0] n1_speed;
    logic [ANG_W-1:0] n1_d;

    logic             r2_valid;
    logic [NUM_WHEELS-1:0][ARG_W-1:0] r2_arg;
    logic [NUM_WHEELS-1:0]            r2_neg;
    logic [SPD_W-1:0] r2_speed;
    logic signed [15:0] r2_corr;
    logic [NUM_WHEELS-1:0][ARG_W-1:0] n2_arg;
    logic [NUM_WHEELS-1:0]            n2_neg;

    logic             r3_valid;
    logic [NUM_WHEELS-1:0][SIN_W-1:0] w3_sin;
    logic [NUM_WHEELS-1:0]            r3_neg;
    logic [SPD_W-1:0] r3_speed;
    logic signed [15:0] r3_corr;

    logic             r4_valid;
    logic [NUM_WHEELS-1:0][MAG_W-1:0] r4_mag;
    logic [NUM_WHEELS-1:0]            r4_vneg;
    logic [SPD_W-1:0] r4_speed;
    logic [NUM_WHEELS-1:0][MAG_W-1:0] n4_mag;
    logic [NUM_WHEELS-1:0]            n4_vneg;

    logic             r5_valid;
    logic [NUM_WHEELS-1:0][MAG_W-1:0] r5_mag;
    logic [NUM_WHEELS-1:0]            r5_vneg;
    logic [SPD_W-1:0] r5_speed;
    logic [MAG_W-1:0] r5_max;
    logic [MAG_W-1:0] n5_max;

    logic             r6_valid;
    logic [NUM_WHEELS-1:0][REM_W-1:0] r6_num;
    logic [MAG_W-1:0] r6_div;
    t_div_side        r6_side;

    logic             d_valid;
    logic [NUM_WHEELS-1:0][Q_W-1:0] d_quo;
    t_div_side        d_side;

    logic             r_out_valid;
    logic signed [15:0] r_out_spd [NUM_WHEELS];
    logic             r_out_zero;
    logic signed [15:0] n_out_spd [NUM_WHEELS];

    logic             out_all_zero;
    logic             out_in_bound;

    // The pipeline moves whenever the output register is empty or being taken.
    assign en         = !r_out_valid || o_out.ready;
    assign i_in.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slow_factor <= CFG_W'(CFG_RESET);
        end else if (i_cfg_we) begin
            r_slow_factor <= i_cfg_data;
        end
    end

    // Stage 1: speed scaling and clamp, relative angle reduced to one turn.
    always_comb begin
        logic [16:0]        prod;
        logic [8:0]         sp;
        logic signed [16:0] dw;
        logic [15:0]        n;
        prod = 17'(r_slow_factor) * 17'(i_in.speed_request);
        sp   = i_in.slowdown ? prod[16:8] : {1'b0, i_in.speed_request};
        n1_speed = (sp > 9'(SPEED_MAX)) ? SPD_W'(SPEED_MAX) : sp[SPD_W-1:0];
        // A bias of three turns keeps the difference nonnegative.
        dw = 17'(i_in.chassis_heading) - 17'(i_in.travel_direction) + 17'(3 * ANG_FULL);
        n  = dw[15:0];
        priority if (n >= 16'(5 * ANG_FULL)) begin
            n1_d = ANG_W'(n - 16'(5 * ANG_FULL));
        end else if (n >= 16'(4 * ANG_FULL)) begin
            n1_d = ANG_W'(n - 16'(4 * ANG_FULL));
        end else if (n >= 16'(3 * ANG_FULL)) begin
            n1_d = ANG_W'(n - 16'(3 * ANG_FULL));
        end else if (n >= 16'(2 * ANG_FULL)) begin
            n1_d = ANG_W'(n - 16'(2 * ANG_FULL));
        end else if (n >= 16'(ANG_FULL)) begin
            n1_d = ANG_W'(n - 16'(ANG_FULL));
        end else begin
            n1_d = ANG_W'(n);
        end
    end

    // Stage 2: wheel angles folded into a quarter-wave table address and a sign.
    always_comb begin
        logic [13:0]      s;
        logic [ANG_W-1:0] a;
        logic [1:0]       q;
        logic [ARG_W-1:0] r;
        for (int l = 0; l < NUM_WHEELS; l++) begin
            s = 14'(r1_d) + WHEEL_OFF[l];
            a = (s >= 14'(ANG_FULL)) ? ANG_W'(s - 14'(ANG_FULL)) : ANG_W'(s);
            priority if (a >= ANG_W'(3 * ANG_QUARTER)) begin
                q = 2'd3;
                r = ARG_W'(a - ANG_W'(3 * ANG_QUARTER));
            end else if (a >= ANG_W'(2 * ANG_QUARTER)) begin
                q = 2'd2;
                r = ARG_W'(a - ANG_W'(2 * ANG_QUARTER));
            end else if (a >= ANG_W'(ANG_QUARTER)) begin
                q = 2'd1;
                r = ARG_W'(a - ANG_W'(ANG_QUARTER));
            end else begin
                q = 2'd0;
                r = ARG_W'(a);
            end
            n2_arg[l] = q[0] ? ARG_W'(ANG_QUARTER) - r : r;
            n2_neg[l] = q[1];
        end
    end

    // Stage 3: table lookup, one ROM per wheel.
    for (genvar l = 0; l < NUM_WHEELS; l++) begin : g_rom
        owvm_sin_rom u_rom (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_addr (r2_arg[l]),
            .o_data (w3_sin[l])
        );
    end

    // Stage 4: wheel term minus the correction, split into magnitude and sign.
    always_comb begin
        logic signed [17:0] sw;
        logic signed [17:0] v;
        for (int l = 0; l < NUM_WHEELS; l++) begin
            sw = r3_neg[l] ? -$signed({6'b0, w3_sin[l]}) : $signed({6'b0, w3_sin[l]});
            v  = sw - 18'(r3_corr);
            n4_vneg[l] = v[17];
            n4_mag[l]  = v[17] ? MAG_W'(-v) : MAG_W'(v);
        end
    end

    // Stage 5: largest magnitude.
    always_comb begin
        logic [MAG_W-1:0] m01;
        logic [MAG_W-1:0] m23;
        m01    = (r4_mag[0] > r4_mag[1]) ? r4_mag[0] : r4_mag[1];
        m23    = (r4_mag[2] > r4_mag[3]) ? r4_mag[2] : r4_mag[3];
        n5_max = (m01 > m23) ? m01 : m23;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid    <= 1'b0;
            r2_valid    <= 1'b0;
            r3_valid    <= 1'b0;
            r4_valid    <= 1'b0;
            r5_valid    <= 1'b0;
            r6_valid    <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r1_valid    <= i_in.valid;
            r2_valid    <= r1_valid;
            r3_valid    <= r2_valid;
            r4_valid    <= r3_valid;
            r5_valid    <= r4_valid;
            r6_valid    <= r5_valid;
            r_out_valid <= d_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_speed <= n1_speed;
            r1_d     <= n1_d;
            r1_corr  <= i_in.rotation_correction;
            r2_arg   <= n2_arg;
            r2_neg   <= n2_neg;
            r2_speed <= r1_speed;
            r2_corr  <= r1_corr;
            r3_neg   <= r2_neg;
            r3_speed <= r2_speed;
            r3_corr  <= r2_corr;
            r4_mag   <= n4_mag;
            r4_vneg  <= n4_vneg;
            r4_speed <= r3_speed;
            r5_mag   <= r4_mag;
            r5_vneg  <= r4_vneg;
            r5_speed <= r4_speed;
            r5_max   <= n5_max;
            // Stage 6: rounded numerator; a zero maximum divides by one and is masked.
            for (int l = 0; l < NUM_WHEELS; l++) begin
                r6_num[l] <= ((REM_W'(r5_mag[l]) * REM_W'(r5_speed)) << 8)
                             + REM_W'(r5_max >> 1);
            end
            r6_div       <= (r5_max == '0) ? MAG_W'(1) : r5_max;
            r6_side      <= '{vneg: r5_vneg, zero: (r5_max == '0)};
            r_out_spd    <= n_out_spd;
            r_out_zero   <= d_side.zero;
        end
    end

    owvm_div_pipe u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r6_valid),
        .i_num   (r6_num),
        .i_div   (r6_div),
        .i_side  (r6_side),
        .o_valid (d_valid),
        .o_quo   (d_quo),
        .o_side  (d_side)
    );

    // Output sign is opposite to the wheel term.
    always_comb begin
        logic signed [15:0] q16;
        for (int l = 0; l < NUM_WHEELS; l++) begin
            q16 = $signed({1'b0, d_quo[l]});
            if (d_side.zero) begin
                n_out_spd[l] = '0;
            end else if (d_side.vneg[l]) begin
                n_out_spd[l] = q16;
            end else begin
                n_out_spd[l] = -q16;
            end
        end
    end

    assign o_out.valid             = r_out_valid;
    assign o_out.front_right_speed = r_out_spd[0];
    assign o_out.front_left_speed  = r_out_spd[1];
    assign o_out.rear_right_speed  = r_out_spd[2];
    assign o_out.rear_left_speed   = r_out_spd[3];
    assign o_out.zero_norm         = r_out_zero;

    assign out_all_zero = (r_out_spd[0] == 16'sd0) && (r_out_spd[1] == 16'sd0)
                          && (r_out_spd[2] == 16'sd0) && (r_out_spd[3] == 16'sd0);
    assign out_in_bound = (r_out_spd[0] >= -16'sd25600) && (r_out_spd[0] <= 16'sd25600)
                          && (r_out_spd[1] >= -16'sd25600) && (r_out_spd[1] <= 16'sd25600)
                          && (r_out_spd[2] >= -16'sd25600) && (r_out_spd[2] <= 16'sd25600)
                          && (r_out_spd[3] >= -16'sd25600) && (r_out_spd[3] <= 16'sd25600);

    `OWVM_ASSERT_IMPLY(a_zero_outputs, r_out_valid && r_out_zero, out_all_zero, "zero speed")
    `OWVM_ASSERT_IMPLY(a_speed_bound, r_out_valid, out_in_bound, "speed out of range")
    `OWVM_ASSERT_NEXT(a_held_result, r_out_valid && !en, r_out_valid && $stable(r_out_zero) && $stable(r_out_spd[0]), "held result changed")

endmodule

`default_nettype wire

/* tb/sv/tb_wheel_mix_scoreboard.sv */
// Scoreboard for the omni wheel velocity mixer: predicts the four wheel commands.
// Depends on owvm_pkg for the configuration width and the angle and speed constants.
`default_nettype none

class wheel_mix_scoreboard;
    typedef struct packed {
        logic signed [15:0] fr;
        logic signed [15:0] fl;
        logic signed [15:0] rr;
        logic signed [15:0] rl;
        logic               zero;
    } t_wheel_cmd;

    t_wheel_cmd pending_cmds[$];
    logic [owvm_pkg::CFG_W-1:0] slow_factor;
    int errors;

    function new();
        slow_factor = owvm_pkg::CFG_W'(owvm_pkg::CFG_RESET);
        errors = 0;
    endfunction

    // Truncated Q30 Horner series, then 15 * sin in Q4.8 rounded half up.
    function automatic int quarter_wave(int r);
        longint unsigned x, x2, t, s;
        longint unsigned one;
        one = 64'd1 << 30;
        x  = 64'(r) * 64'd1171271;
        x2 = (x * x) >> 30;
        t  = one - x2 / 72;
        t  = one - ((x2 * t) >> 30) / 42;
        t  = one - ((x2 * t) >> 30) / 20;
        t  = one - ((x2 * t) >> 30) / 6;
        s  = (x * t) >> 30;
        return int'((64'd15 * s + (64'd1 << 21)) >> 22);
    endfunction

    function automatic int wheel_sine(int a);
        int q, r, w;
        q = a / owvm_pkg::ANG_QUARTER;
        r = a % owvm_pkg::ANG_QUARTER;
        w = quarter_wave((q & 1) ? owvm_pkg::ANG_QUARTER - r : r);
        return (q >= 2) ? -w : w;
    endfunction

    function void note_item(logic signed [13:0] dir, logic signed [13:0] head,
                            logic signed [15:0] corr, logic [7:0] req, logic slow);
        int speed, d, maxm;
        int v[4];
        int mag[4];
        int offs[4];
        longint num, s;
        logic signed [15:0] o[4];
        t_wheel_cmd c;
        offs = '{880, 4880, 2320, 3440};
        speed = req;
        if (slow) speed = (int'(slow_factor) * speed) >> 8;
        if (speed > owvm_pkg::SPEED_MAX) speed = owvm_pkg::SPEED_MAX;
        d = (int'(head) - int'(dir)) % owvm_pkg::ANG_FULL;
        if (d < 0) d += owvm_pkg::ANG_FULL;
        maxm = 0;
        for (int i = 0; i < 4; i++) begin
            v[i] = wheel_sine((d + offs[i]) % owvm_pkg::ANG_FULL) - int'(corr);
            mag[i] = v[i] < 0 ? -v[i] : v[i];
            if (mag[i] > maxm) maxm = mag[i];
        end
        c = '0;
        if (maxm == 0) begin
            c.zero = 1'b1;
        end else begin
            for (int i = 0; i < 4; i++) begin
                num = longint'(mag[i]) * speed * 256 + maxm / 2;
                s = num / maxm;
                o[i] = 16'(v[i] >= 0 ? -s : s);
            end
            c.fr = o[0];
            c.fl = o[1];
            c.rr = o[2];
            c.rl = o[3];
        end
        pending_cmds.push_back(c);
    endfunction

    task automatic report(string what, int got, int want);
        $display("mismatch %s: got %0d, want %0d", what, got, want);
        errors++;
    endtask

    task automatic check_result(t_wheel_cmd got);
        t_wheel_cmd want;
        if (pending_cmds.size() == 0) begin
            report("unexpected transfer", 0, 0);
            return;
        end
        want = pending_cmds.pop_front();
        if (got.fr !== want.fr) report("front_right", got.fr, want.fr);
        if (got.fl !== want.fl) report("front_left", got.fl, want.fl);
        if (got.rr !== want.rr) report("rear_right", got.rr, want.rr);
        if (got.rl !== want.rl) report("rear_left", got.rl, want.rl);
        if (got.zero !== want.zero) report("zero_norm", got.zero, want.zero);
    endtask
endclass

`default_nettype wire

/* tb/sv/tb.sv */
// Top-level testbench of the omni wheel velocity mixer: directed and random items,
// random item idling, random result stalls. Depends on owvm_pkg, owvm_if, the scoreboard.
`default_nettype none

module tb;
    localparam int LATENCY = 22;
    localparam int CYCLE_LIMIT = 400000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [owvm_pkg::CFG_W-1:0] i_cfg_data = '0;
    int cycles = 0;
    bit long_hold = 1'b0;

    owvm_in_if  item_ch();
    owvm_out_if cmd_ch();

    wheel_mix_scoreboard sb = new();

    omni_wheel_velocity_mixer_unit u_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_data(i_cfg_data),
        .i_in      (item_ch.sink),
        .o_out     (cmd_ch.source)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        item_ch.valid = 1'b0;
        item_ch.travel_direction = '0;
        item_ch.chassis_heading = '0;
        item_ch.rotation_correction = '0;
        item_ch.speed_request = '0;
        item_ch.slowdown = 1'b0;
        cmd_ch.ready = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: done, errors");
            $finish;
        end
    end

    // Result side: random stalls, plus one long hold-off driven by the stimulus.
    initial begin
        int gap;
        forever begin
            @(posedge i_clk);
            if (!i_rst_n) continue;
            if (long_hold) begin
                cmd_ch.ready <= 1'b0;
                continue;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
            if (gap != 0 && $urandom_range(0, 1) == 0) begin
                cmd_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            cmd_ch.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && cmd_ch.valid && cmd_ch.ready)
            sb.check_result({cmd_ch.front_right_speed, cmd_ch.front_left_speed,
                             cmd_ch.rear_right_speed, cmd_ch.rear_left_speed,
                             cmd_ch.zero_norm});
    end

    task automatic send_item(logic signed [13:0] dir, logic signed [13:0] head,
                             logic signed [15:0] corr, logic [7:0] req, logic slow,
                             bit may_idle);
        int gap;
        gap = may_idle ? $urandom_range(0, 13) : 0;
        if (may_idle && $urandom_range(0, 2) == 0) gap = 0;
        if (gap != 0) begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        item_ch.valid <= 1'b1;
        item_ch.travel_direction <= dir;
        item_ch.chassis_heading <= head;
        item_ch.rotation_correction <= corr;
        item_ch.speed_request <= req;
        item_ch.slowdown <= slow;
        @(posedge i_clk);
        while (!item_ch.ready) @(posedge i_clk);
        sb.note_item(dir, head, corr, req, slow);
    endtask

    task automatic drain();
        item_ch.valid <= 1'b0;
        while (sb.pending_cmds.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic write_factor(logic [owvm_pkg::CFG_W-1:0] f);
        i_cfg_we <= 1'b1;
        i_cfg_data <= f;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.slow_factor = f;
    endtask

    task automatic send_random(int n, bit may_idle);
        logic signed [13:0] dir, head;
        logic signed [15:0] corr;
        for (int k = 0; k < n; k++) begin
            case ($urandom_range(0, 5))
                0: begin
                    dir = 14'($urandom);
                    head = 14'($urandom);
                end
                default: begin
                    dir = 14'($signed($urandom_range(0, 11520)) - 5760);
                    head = 14'($signed($urandom_range(0, 11520)) - 5760);
                end
            endcase
            case ($urandom_range(0, 4))
                0: corr = 16'($urandom);
                1: corr = 16'($signed($urandom_range(0, 7680)) - 3840);
                default: corr = 16'($signed($urandom_range(0, 600)) - 300);
            endcase
            send_item(dir, head, corr, 8'($urandom), 1'($urandom), may_idle);
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: field extremes, zero speed and saturation.
        send_item(14'sd0, 14'sd0, 16'sd0, 8'd100, 1'b0, 1'b0);
        send_item(-14'sd5760, 14'sd5760, 16'sd0, 8'd255, 1'b0, 1'b0);
        send_item(14'sd5760, -14'sd5760, 16'sd25600, 8'd0, 1'b0, 1'b0);
        send_item(-14'sd8192, 14'sd8191, -16'sd32768, 8'd255, 1'b1, 1'b0);
        send_item(14'sd8191, -14'sd8192, 16'sd32767, 8'd1, 1'b1, 1'b0);
        send_item(14'sd1440, 14'sd0, -16'sd25600, 8'd50, 1'b0, 1'b0);
        send_item(14'sd0, 14'sd2880, 16'sd100, 8'd99, 1'b1, 1'b0);
        send_item(14'sd720, 14'sd720, 16'sd0, 8'd101, 1'b0, 1'b0);
        send_item(14'sd0, 14'sd0, 16'sd0, 8'd0, 1'b0, 1'b0);
        // Directions in steps of 45 degrees with small corrections.
        for (int a = 0; a < 8; a++)
            send_item(14'(a * 720), 14'sd0, 16'(-a), 8'($urandom), 1'($urandom), 1'b0);
        drain();

        // Factor sweep, extremes included; the mixer must be idle for each write.
        write_factor(9'd0);
        send_random(60, 1'b1);
        drain();
        write_factor(9'd511);
        send_random(60, 1'b1);
        drain();
        write_factor(9'd1);
        send_random(40, 1'b1);
        drain();

        // Long result stall so the pipeline fills and backs up the input.
        write_factor(9'd128);
        fork
            begin
                long_hold = 1'b1;
                repeat (300) @(posedge i_clk);
                long_hold = 1'b0;
            end
            send_random(80, 1'b0);
        join
        drain();

        write_factor(9'($urandom_range(0, 511)));
        send_random(300, 1'b1);
        drain();
        write_factor(9'd256);
        send_random(120, 1'b0);
        send_random(200, 1'b1);
        drain();

        if (sb.errors == 0 && sb.pending_cmds.size() == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end
endmodule

`default_nettype wire
